// File: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic       push;        // shift one byte into the block register
        logic [7:0] push_data;   // byte to shift in
        logic       load;        // copy chain words into working words
        logic       rnd;         // run one compression round
        logic [5:0] rnd_idx;     // round number
        logic       add;         // fold working words into chain words
        logic       init;        // restore initial hash values
        logic [2:0] out_idx;     // chain word shown on the output
    } sha256_ctl_t;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_TOP = 6'd63;
    localparam logic [5:0] RND_TOP  = 6'd63;
    localparam logic [3:0] LEN_DONE = 4'd8;
    localparam logic [2:0] WORD_TOP = 3'd7;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        rotr = (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

// File: hw/rtl/sha256_sched.sv
// ----------------------------------------------------------------------------
// sha256_sched
// Block register and message schedule: bytes shift in during gathering, then
// the same sixteen words roll once per round to expand the schedule.
// ----------------------------------------------------------------------------
module sha256_sched (
    input  logic                     clk,
    input  sha256_pkg::sha256_ctl_t  ctl,
    output logic [31:0]              w_cur
);
    import sha256_pkg::*;

    logic [31:0] w_reg  [16];
    logic [31:0] w_next [16];
    logic [31:0] w_new;

    // next schedule word from fixed taps
    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign w_cur = w_reg[0];

    // byte shift while gathering, word shift while rounds run
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (ctl.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = {w_reg[i][23:0], w_reg[i+1][31:24]};
            end
            w_next[15] = {w_reg[15][23:0], ctl.push_data};
        end
        else if (ctl.rnd)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[15] = w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

endmodule

// File: hw/rtl/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// Shared compression round unit with working words a..h and chain words.
// ----------------------------------------------------------------------------
module sha256_round (
    input  logic                     clk,
    input  logic                     rst_n,
    input  sha256_pkg::sha256_ctl_t  ctl,
    input  logic [31:0]              w_cur,
    output logic [31:0]              digest_word
);
    import sha256_pkg::*;

    logic [31:0] v_reg  [8];
    logic [31:0] v_next [8];
    logic [31:0] h_reg  [8];
    logic [31:0] h_next [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] chs;
    logic [31:0] mj;

    // round function
    assign chs = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + big_sigma1(v_reg[4]) + chs + ROUND_K[ctl.rnd_idx] + w_cur;
    assign t2  = big_sigma0(v_reg[0]) + mj;

    // working word update
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_next[i] = v_reg[i];
        end
        if (ctl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_next[i] = h_reg[i];
            end
        end
        else if (ctl.rnd)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // chain word update
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_next[i] = h_reg[i];
        end
        if (ctl.init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = INIT_H[i];
            end
        end
        else if (ctl.add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            v_reg[i] <= v_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    assign digest_word = h_reg[ctl.out_idx];

endmodule

// File: hw/rtl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: byte intake, padding, round counting and digest readout.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               in_byte,
    input  logic                     in_byte_valid,
    input  logic                     in_last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_index,
    output logic                     out_last,
    output sha256_pkg::sha256_ctl_t  ctl
);
    import sha256_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_length_reg, bit_length_next;
    logic        pad_active_reg, pad_active_next;
    logic        mark_done_reg, mark_done_next;
    logic [3:0]  len_idx_reg, len_idx_next;
    logic [5:0]  rnd_cnt_reg, rnd_cnt_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    logic        in_fire;
    logic        out_fire;
    logic        len_phase;
    logic [7:0]  pad_data;
    logic        finish;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign finish   = out_fire && (out_idx_reg == WORD_TOP);

    // padding byte: marker, zeros up to the length field, then length big-endian
    assign len_phase = mark_done_reg && ((len_idx_reg != 4'd0) || (fill_reg == LEN_POS));
    always_comb
    begin
        if (!mark_done_reg)
        begin
            pad_data = PAD_MARK;
        end
        else if (len_phase)
        begin
            pad_data = bit_length_reg[(6'd56 - {len_idx_reg[2:0], 3'b000}) +: 8];
        end
        else
        begin
            pad_data = 8'h00;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_byte_valid && (fill_reg == FILL_TOP))
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == FILL_TOP)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rnd_cnt_reg == RND_TOP)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!pad_active_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_idx_reg == LEN_DONE)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls and handshakes
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        ctl.push      = 1'b0;
        ctl.push_data = in_byte;
        ctl.load      = 1'b0;
        ctl.rnd       = 1'b0;
        ctl.rnd_idx   = rnd_cnt_reg;
        ctl.add       = 1'b0;
        ctl.init      = 1'b0;
        ctl.out_idx   = out_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire && in_byte_valid)
                begin
                    ctl.push = 1'b1;
                    ctl.load = (fill_reg == FILL_TOP);
                end
            end
            ST_PAD:
            begin
                ctl.push      = 1'b1;
                ctl.push_data = pad_data;
                ctl.load      = (fill_reg == FILL_TOP);
            end
            ST_ROUND:
            begin
                ctl.rnd = 1'b1;
            end
            ST_ADD:
            begin
                ctl.add = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                ctl.init  = finish;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_index = out_idx_reg;
    assign out_last  = (out_idx_reg == WORD_TOP);

    // counters and message bookkeeping
    always_comb
    begin
        fill_next       = fill_reg;
        bit_length_next = bit_length_reg;
        pad_active_next = pad_active_reg;
        mark_done_next  = mark_done_reg;
        len_idx_next    = len_idx_reg;
        rnd_cnt_next    = rnd_cnt_reg;
        out_idx_next    = out_idx_reg;
        if (ctl.push)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if ((state_reg == ST_IDLE) && in_fire)
        begin
            if (in_byte_valid)
            begin
                bit_length_next = bit_length_reg + 64'd8;
            end
            if (in_last)
            begin
                pad_active_next = 1'b1;
            end
        end
        if (state_reg == ST_PAD)
        begin
            mark_done_next = 1'b1;
            if (len_phase)
            begin
                len_idx_next = len_idx_reg + 4'd1;
            end
        end
        if (ctl.rnd)
        begin
            rnd_cnt_next = rnd_cnt_reg + 6'd1;
        end
        if (out_fire)
        begin
            out_idx_next = out_idx_reg + 3'd1;
        end
        if (finish)
        begin
            bit_length_next = 64'd0;
            pad_active_next = 1'b0;
            mark_done_next  = 1'b0;
            len_idx_next    = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 6'd0;
            bit_length_reg <= 64'd0;
            pad_active_reg <= 1'b0;
            mark_done_reg  <= 1'b0;
            len_idx_reg    <= 4'd0;
            rnd_cnt_reg    <= 6'd0;
            out_idx_reg    <= 3'd0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bit_length_reg <= bit_length_next;
            pad_active_reg <= pad_active_next;
            mark_done_reg  <= mark_done_next;
            len_idx_reg    <= len_idx_next;
            rnd_cnt_reg    <= rnd_cnt_next;
            out_idx_reg    <= out_idx_next;
        end
    end

endmodule

// File: hw/rtl/sha256_hasher.sv
// ----------------------------------------------------------------------------
// sha256_hasher
// SHA-256 over a byte stream; emits the eight digest words after the last beat.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while a block fills; each full 64-byte
//   block then holds the input while the single shared round unit runs the
//   rounds and one chain update follows.
// Finish: after the last beat, padding feeds one byte per cycle (at most 72
//   bytes over two final blocks), each full block passing through the rounds
//   and a chain update before the 8 output beats are shown one by one.
// Reset: rst_n clears the sequencer and loads the initial hash values at once.
module sha256_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] byte_valid
    input  logic        s_tlast,    // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic [2:0]  m_tuser,    // [2:0] word_index
    output logic        m_tlast     // last_word
);
    import sha256_pkg::*;

    sha256_ctl_t ctl;
    logic [31:0] w_cur;

    // sequencer
    sha256_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .in_byte_valid (s_tuser),
        .in_last       (s_tlast),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_index     (m_tuser),
        .out_last      (m_tlast),
        .ctl           (ctl)
    );

    // block register and schedule
    sha256_sched u_sched (
        .clk   (clk),
        .ctl   (ctl),
        .w_cur (w_cur)
    );

    // round unit and chain words
    sha256_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .w_cur       (w_cur),
        .digest_word (m_tdata)
    );

endmodule
